### sv/cfd_pkg.sv
// cfd_pkg: shared types and constants for the command frame deframer
// parse positions, framing bytes, register indexes, mode code and frame structs
// no dependencies
package cfd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [ByteW-1:0] SYNC_BYTE = 8'h23;
    localparam logic [ByteW-1:0] END_BYTE = 8'h21;

    localparam logic [CfgIdxW-1:0] CFG_MODE_FIRST = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MODE_SECOND = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MODE_THIRD = 2'd2;

    localparam logic [ByteW-1:0] MODE_FIRST_RST = 8'd0;
    localparam logic [ByteW-1:0] MODE_SECOND_RST = 8'd1;
    localparam logic [ByteW-1:0] MODE_THIRD_RST = 8'd2;

    typedef enum logic [2:0] {
        POS_SYNC = 3'd0,
        POS_MODE = 3'd1,
        POS_THROTTLE = 3'd2,
        POS_ROLL = 3'd3,
        POS_PITCH = 3'd4,
        POS_YAW = 3'd5,
        POS_END = 3'd6
    } t_parse_pos;

    typedef struct packed {
        logic [ByteW-1:0] first;
        logic [ByteW-1:0] second;
        logic [ByteW-1:0] third;
    } t_mode_codes;

    typedef struct packed {
        logic [ByteW-1:0] mode;
        logic signed [ByteW-1:0] throttle;
        logic signed [ByteW-1:0] roll;
        logic signed [ByteW-1:0] pitch;
        logic signed [ByteW-1:0] yaw;
    } t_frame;

endpackage

### sv/cfd_byte_if.sv
// cfd_byte_if: valid/ready channel carrying one received byte
// depends on cfd_pkg
interface cfd_byte_if import cfd_pkg::*; ();
    logic valid;
    logic ready;
    logic [ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/cfd_frame_if.sv
// cfd_frame_if: valid/ready channel carrying one decoded command frame
// depends on cfd_pkg
interface cfd_frame_if import cfd_pkg::*; ();
    logic valid;
    logic ready;
    logic [ByteW-1:0] mode;
    logic signed [ByteW-1:0] throttle;
    logic signed [ByteW-1:0] roll;
    logic signed [ByteW-1:0] pitch;
    logic signed [ByteW-1:0] yaw;

    modport source (output valid, output mode, output throttle, output roll,
                    output pitch, output yaw, input ready);
    modport sink (input valid, input mode, input throttle, input roll,
                  input pitch, input yaw, output ready);
endinterface

### sv/cfd_cfg_regs.sv
// cfd_cfg_regs: the three mode code registers and their write port
// depends on cfd_pkg
module cfd_cfg_regs import cfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [ByteW-1:0]   i_cfg_data,
    output t_mode_codes        o_codes
);

    t_mode_codes r_codes;
    t_mode_codes n_codes;

    always_comb begin
        n_codes = r_codes;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE_FIRST:  n_codes.first = i_cfg_data;
                CFG_MODE_SECOND: n_codes.second = i_cfg_data;
                CFG_MODE_THIRD:  n_codes.third = i_cfg_data;
                default:         n_codes = r_codes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.first <= MODE_FIRST_RST;
            r_codes.second <= MODE_SECOND_RST;
            r_codes.third <= MODE_THIRD_RST;
        end else begin
            r_codes <= n_codes;
        end
    end

    assign o_codes = r_codes;

endmodule

### sv/cfd_parser.sv
// cfd_parser: input byte register, frame position state machine and held fields
// depends on cfd_pkg
module cfd_parser import cfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ByteW-1:0] i_in_byte,
    output logic             o_in_ready,
    input  t_mode_codes      i_codes,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output t_frame           o_res
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    t_parse_pos       r_pos;
    t_parse_pos       n_pos;
    t_frame           r_held;
    t_frame           n_held;
    logic             w_adv;
    logic             w_mode_ok;

    assign w_adv = r_in_valid && i_out_free;
    assign o_in_ready = !r_in_valid || i_out_free;
    assign w_mode_ok = (r_in_byte == i_codes.first) || (r_in_byte == i_codes.second)
                       || (r_in_byte == i_codes.third);

    // next position
    always_comb begin
        case (r_pos)
            POS_MODE:     n_pos = w_mode_ok ? POS_THROTTLE : POS_SYNC;
            POS_THROTTLE: n_pos = POS_ROLL;
            POS_ROLL:     n_pos = POS_PITCH;
            POS_PITCH:    n_pos = POS_YAW;
            POS_YAW:      n_pos = POS_END;
            POS_END:      n_pos = POS_SYNC;
            default:      n_pos = (r_in_byte == SYNC_BYTE) ? POS_MODE : POS_SYNC;
        endcase
    end

    // held fields and result
    always_comb begin
        n_held = r_held;
        o_res_valid = 1'b0;
        case (r_pos)
            POS_MODE:     n_held.mode = w_mode_ok ? r_in_byte : r_held.mode;
            POS_THROTTLE: n_held.throttle = r_in_byte;
            POS_ROLL:     n_held.roll = r_in_byte;
            POS_PITCH:    n_held.pitch = r_in_byte;
            POS_YAW:      n_held.yaw = r_in_byte;
            POS_END:      o_res_valid = w_adv && (r_in_byte == END_BYTE);
            default:      n_held = r_held;
        endcase
    end

    assign o_res = r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos <= POS_SYNC;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
        if (w_adv) begin
            r_held <= n_held;
        end
    end

endmodule

### sv/cfd_out_reg.sv
// cfd_out_reg: result register holding one decoded frame until taken
// depends on cfd_pkg
module cfd_out_reg import cfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_res_valid,
    input  t_frame i_res,
    output logic   o_free,
    output logic   o_valid,
    input  logic   i_ready,
    output t_frame o_frame
);

    logic   r_valid;
    t_frame r_frame;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_frame <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

### sv/command_frame_deframer_unit.sv
// command_frame_deframer_unit: top level of the command frame deframer
// depends on cfd_pkg, cfd_byte_if, cfd_frame_if, cfd_cfg_regs, cfd_parser, cfd_out_reg
//
// Bytes enter one per item and are parsed for the frame '#', mode, throttle, roll,
// pitch, yaw, '!'. The mode byte must equal one of the three mode code registers,
// else the parser returns to hunting for '#'; a wrong terminator drops the frame.
// A complete frame gives one item with the mode and the four signed axis values.
// A taken byte waits in the input byte register and is parsed once the output register
// is free; a finished frame then goes into the output register. One byte is taken every
// cycle while the output register is empty or being emptied; a frame that waits there
// holds the parser, so the input stops after one more byte until that frame is taken.
// Indexes beyond the third register are ignored. The user must write mode codes through
// i_cfg_we / i_cfg_index / i_cfg_data only while no byte is in flight (unchecked).
module command_frame_deframer_unit import cfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfd_byte_if.sink           i_rx_if,
    cfd_frame_if.source        o_frame_if,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [ByteW-1:0]   i_cfg_data
);

    t_mode_codes w_codes;
    logic        w_out_free;
    logic        w_res_valid;
    t_frame      w_res;
    t_frame      w_frame;

    cfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_codes     (w_codes)
    );

    cfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx_if.valid),
        .i_in_byte   (i_rx_if.rx_byte),
        .o_in_ready  (i_rx_if.ready),
        .i_codes     (w_codes),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_valid     (o_frame_if.valid),
        .i_ready     (o_frame_if.ready),
        .o_frame     (w_frame)
    );

    assign o_frame_if.mode = w_frame.mode;
    assign o_frame_if.throttle = w_frame.throttle;
    assign o_frame_if.roll = w_frame.roll;
    assign o_frame_if.pitch = w_frame.pitch;
    assign o_frame_if.yaw = w_frame.yaw;

endmodule
